/* rtl/ddmix_pkg.sv */
package ddmix_pkg;

  // Field widths
  localparam int JoyW     = 11;
  localparam int DistW    = 10;
  localparam int SpeedW   = 12;   // mixed wheel speed, signed
  localparam int MixW     = 13;   // mixing headroom, signed
  localparam int MagW     = 10;
  localparam int PwmW     = 8;
  localparam int SqW      = 2 * JoyW - 1;
  localparam int SumW     = SqW + 1;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 22;

  // Datapath widths of the PWM chain
  localparam int GainW = 16;
  localparam int F8W   = 26;              // offset + gain*mag, Q8
  localparam int ProdW = F8W + GainW;     // times ramp gain
  localparam int RampW = ProdW + DistW;   // times distance margin

  localparam int EmergencyCm = 10;

  // Reset values
  localparam logic [MagW-1:0]  MaxSpeedRst  = 10'd100;
  localparam logic [SumW-1:0]  DeadZoneRst  = 22'd25;
  localparam logic [PwmW-1:0]  MinPwmRst    = 8'd0;
  localparam logic [GainW-1:0] PwmGainRst   = 16'd256;
  localparam logic [DistW-1:0] RampStartRst = 10'd100;
  localparam logic [DistW-1:0] RampStopRst  = 10'd10;
  localparam logic [GainW-1:0] RampGainRst  = 16'd728;

  typedef enum logic [1:0] {
    BrCoast = 2'd0,
    BrFwd   = 2'd1,
    BrRev   = 2'd2,
    BrBrake = 2'd3
  } bridge_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxSpeed  = 3'd0,
    CfgDeadZone  = 3'd1,
    CfgMinPwm    = 3'd2,
    CfgPwmGain   = 3'd3,
    CfgRampStart = 3'd4,
    CfgRampStop  = 3'd5,
    CfgRampGain  = 3'd6
  } cfg_idx_e;

  // Per-wheel command handed into the PWM chain
  typedef struct packed {
    logic [MagW-1:0]  mag;
    logic             ramp;   // distance inside ramp zone
    logic             kill;   // force zero duty
    logic [DistW-1:0] dm;     // distance minus ramp stop
  } wheel_cmd_t;

  typedef struct packed {
    logic [PwmW-1:0]  min_pwm;
    logic [GainW-1:0] pwm_gain;
    logic [GainW-1:0] ramp_gain;
  } wheel_cfg_t;

  // Load enables of the three chain stages
  typedef struct packed {
    logic a;
    logic b;
    logic c;
  } wheel_en_t;

endpackage

/* rtl/ddmix_wheel.sv */
module ddmix_wheel import ddmix_pkg::*; (
  input  logic            clk_i,
  input  wheel_en_t       en_i,
  input  wheel_cfg_t      cfg_i,
  input  wheel_cmd_t      cmd_i,
  output logic [PwmW-1:0] pwm_o
);

  logic [F8W-1:0]   gm;
  logic [F8W-1:0]   f8_d;
  logic [F8W-1:0]   f8_a_q, f8_b_q, f8_c_q;
  logic [ProdW-1:0] prod_d, prod_q;
  logic [RampW-1:0] ramp_d, ramp_q;
  wheel_cmd_t       cmd_a_q, cmd_b_q, cmd_c_q;

  // stage a: offset plus gain times magnitude, Q8
  assign gm   = cfg_i.pwm_gain * cmd_i.mag;
  assign f8_d = gm + {{(F8W-PwmW-8){1'b0}}, cfg_i.min_pwm, 8'b0};

  // stage b: times ramp slope
  assign prod_d = f8_a_q * cfg_i.ramp_gain;

  // stage c: times distance margin
  assign ramp_d = prod_q * cmd_b_q.dm;

  always_ff @(posedge clk_i) begin
    if (en_i.a) begin
      f8_a_q  <= f8_d;
      cmd_a_q <= cmd_i;
    end
    if (en_i.b) begin
      prod_q  <= prod_d;
      f8_b_q  <= f8_a_q;
      cmd_b_q <= cmd_a_q;
    end
    if (en_i.c) begin
      ramp_q  <= ramp_d;
      f8_c_q  <= f8_b_q;
      cmd_c_q <= cmd_b_q;
    end
  end

  // floor and saturate
  always_comb begin
    if (cmd_c_q.kill) begin
      pwm_o = '0;
    end else if (cmd_c_q.ramp) begin
      pwm_o = (|ramp_q[RampW-1:32]) ? {PwmW{1'b1}} : ramp_q[31:24];
    end else begin
      pwm_o = (|f8_c_q[F8W-1:16]) ? {PwmW{1'b1}} : f8_c_q[15:8];
    end
  end

endmodule

/* rtl/differential_drive_mixer_core.sv */
// Differential-drive mixer. Each transaction on the input channel carries one
// joystick sample (x steering, y throttle, positive forward), the front and
// rear radar distances and four infrared obstacle flags; exactly one result
// transaction follows, in order, with two PWM duty bytes, two H-bridge codes
// (0 coast, 1 forward, 2 reverse; brake is never issued) and an emergency
// flag. The pipeline is six register stages deep, and a new sample is taken
// every cycle while the output side keeps up. The depth is set by the PWM
// chain, which runs the gain multiply, the ramp-slope multiply and the
// distance multiply in separate stages. Back-pressure from the output stalls
// only the stages that are full; empty stages keep filling. Registers are
// written through the cfg port (always ready), one per transaction, and must
// be written only while no sample is in flight; unknown indices are ignored.
module differential_drive_mixer_core import ddmix_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [CfgDataW-1:0]     cfg_data_i,
  // input samples
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [JoyW-1:0]  joy_x_i,
  input  logic signed [JoyW-1:0]  joy_y_i,
  input  logic [DistW-1:0]        front_dist_cm_i,
  input  logic [DistW-1:0]        rear_dist_cm_i,
  input  logic                    ir_front_left_i,
  input  logic                    ir_front_right_i,
  input  logic                    ir_rear_left_i,
  input  logic                    ir_rear_right_i,
  // results
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [PwmW-1:0]         left_pwm_o,
  output logic [PwmW-1:0]         right_pwm_o,
  output logic [1:0]              left_bridge_o,
  output logic [1:0]              right_bridge_o,
  output logic                    emergency_o
);

  localparam int NStages = 6;

  typedef struct packed {
    logic    emergency;
    bridge_e lbr;
    bridge_e rbr;
  } side_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [MagW-1:0]  max_speed_q;
  logic [SumW-1:0]  dead_zone_q;
  logic [PwmW-1:0]  min_pwm_q;
  logic [GainW-1:0] pwm_gain_q;
  logic [DistW-1:0] ramp_start_q;
  logic [DistW-1:0] ramp_stop_q;
  logic [GainW-1:0] ramp_gain_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q  <= MaxSpeedRst;
      dead_zone_q  <= DeadZoneRst;
      min_pwm_q    <= MinPwmRst;
      pwm_gain_q   <= PwmGainRst;
      ramp_start_q <= RampStartRst;
      ramp_stop_q  <= RampStopRst;
      ramp_gain_q  <= RampGainRst;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgMaxSpeed:  max_speed_q  <= cfg_data_i[MagW-1:0];
        CfgDeadZone:  dead_zone_q  <= cfg_data_i[SumW-1:0];
        CfgMinPwm:    min_pwm_q    <= cfg_data_i[PwmW-1:0];
        CfgPwmGain:   pwm_gain_q   <= cfg_data_i[GainW-1:0];
        CfgRampStart: ramp_start_q <= cfg_data_i[DistW-1:0];
        CfgRampStop:  ramp_stop_q  <= cfg_data_i[DistW-1:0];
        CfgRampGain:  ramp_gain_q  <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its content moves on
  // ---------------------------------------------------------------------------
  logic [NStages:1] v_q;
  logic [NStages:1] en;
  logic [NStages:0] v_in;

  always_comb begin
    en[NStages] = !v_q[NStages] || out_ready_i;
    for (int k = NStages - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign v_in       = {v_q, in_valid_i};
  assign in_ready_o = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NStages; k++) begin
        if (en[k]) v_q[k] <= v_in[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: squares for the dead zone, x/2 mixing, clamp, infrared blocking
  // ---------------------------------------------------------------------------
  logic signed [2*JoyW-1:0] xsq, ysq;
  logic        [JoyW:0]     hsum;
  logic signed [JoyW-1:0]   half;
  logic signed [MixW-1:0]   ye, he, lim, nlim, lsum, rsum;

  logic [SqW-1:0]           xx_q, yy_q;
  logic                     origin_q;
  logic signed [SpeedW-1:0] l_q, r_q;
  logic [DistW-1:0]         ld_q, rd_q;

  assign xsq = joy_x_i * joy_x_i;
  assign ysq = joy_y_i * joy_y_i;

  // truncate toward zero: add one before the shift when negative
  assign hsum = {joy_x_i[JoyW-1], joy_x_i} + {{JoyW{1'b0}}, joy_x_i[JoyW-1]};
  assign half = hsum[JoyW:1];
  assign ye   = MixW'(joy_y_i);
  assign he   = MixW'(half);
  assign lim  = {{(MixW-MagW){1'b0}}, max_speed_q};
  assign nlim = -lim;

  always_comb begin
    if (!joy_y_i[JoyW-1]) begin
      lsum = ye + he;
      rsum = ye - he;
      if (lsum > lim) lsum = lim;
      if (rsum > lim) rsum = lim;
    end else begin
      lsum = ye - he;
      rsum = ye + he;
      if (lsum < nlim) lsum = nlim;
      if (rsum < nlim) rsum = nlim;
    end
    if (ir_front_left_i  && lsum > 0) lsum = '0;
    if (ir_front_right_i && rsum > 0) rsum = '0;
    if (ir_rear_left_i   && lsum < 0) lsum = '0;
    if (ir_rear_right_i  && rsum < 0) rsum = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      xx_q     <= xsq[SqW-1:0];
      yy_q     <= ysq[SqW-1:0];
      origin_q <= (joy_x_i == '0) && (joy_y_i == '0);
      l_q      <= lsum[SpeedW-1:0];
      r_q      <= rsum[SpeedW-1:0];
      // zero speed counts as forward
      ld_q     <= lsum[MixW-1] ? rear_dist_cm_i : front_dist_cm_i;
      rd_q     <= rsum[MixW-1] ? rear_dist_cm_i : front_dist_cm_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: dead zone, emergency, magnitude and ramp decisions
  // ---------------------------------------------------------------------------
  function automatic wheel_cmd_t make_cmd(
    input logic signed [SpeedW-1:0] speed,
    input logic [DistW-1:0]         range_cm,
    input logic [MagW-1:0]          max_speed,
    input logic [DistW-1:0]         ramp_start,
    input logic [DistW-1:0]         ramp_stop,
    input logic                     stop
  );
    logic [SpeedW-1:0] abs_v;
    wheel_cmd_t        c;
    abs_v  = speed[SpeedW-1] ? SpeedW'(-speed) : SpeedW'(speed);
    c.mag  = (abs_v > {{(SpeedW-MagW){1'b0}}, max_speed}) ? max_speed : abs_v[MagW-1:0];
    c.ramp = range_cm < ramp_start;
    c.kill = stop || (c.mag == '0) || (c.ramp && range_cm <= ramp_stop);
    c.dm   = range_cm - ramp_stop;
    return c;
  endfunction

  logic       dead, emerg, stop;
  wheel_cmd_t lcmd_d, rcmd_d, lcmd_q, rcmd_q;
  side_t      side_d;
  side_t      side_q [2:NStages-1];

  assign dead  = ({1'b0, xx_q} + {1'b0, yy_q} < dead_zone_q) || origin_q;
  assign emerg = (ld_q < DistW'(EmergencyCm)) || (rd_q < DistW'(EmergencyCm));
  assign stop  = dead || emerg;

  always_comb begin
    lcmd_d = make_cmd(l_q, ld_q, max_speed_q, ramp_start_q, ramp_stop_q, stop);
    rcmd_d = make_cmd(r_q, rd_q, max_speed_q, ramp_start_q, ramp_stop_q, stop);
    side_d.emergency = emerg && !dead;
    side_d.lbr = stop ? BrCoast : (l_q[SpeedW-1] ? BrRev : BrFwd);
    side_d.rbr = stop ? BrCoast : (r_q[SpeedW-1] ? BrRev : BrFwd);
  end

  // side data rides alongside the PWM chain, one register per stage
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      lcmd_q    <= lcmd_d;
      rcmd_q    <= rcmd_d;
      side_q[2] <= side_d;
    end
    for (int k = 3; k <= NStages - 1; k++) begin
      if (en[k]) side_q[k] <= side_q[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 3 to 5: PWM chain per wheel
  // ---------------------------------------------------------------------------
  wheel_cfg_t      wcfg;
  wheel_en_t       wen;
  logic [PwmW-1:0] lpwm, rpwm;

  assign wcfg = '{min_pwm: min_pwm_q, pwm_gain: pwm_gain_q, ramp_gain: ramp_gain_q};
  assign wen  = '{a: en[3], b: en[4], c: en[5]};

  ddmix_wheel u_left (
    .clk_i (clk_i),
    .en_i  (wen),
    .cfg_i (wcfg),
    .cmd_i (lcmd_q),
    .pwm_o (lpwm)
  );

  ddmix_wheel u_right (
    .clk_i (clk_i),
    .en_i  (wen),
    .cfg_i (wcfg),
    .cmd_i (rcmd_q),
    .pwm_o (rpwm)
  );

  // ---------------------------------------------------------------------------
  // Stage 6: result register
  // ---------------------------------------------------------------------------
  logic [PwmW-1:0] lpwm_q, rpwm_q;
  side_t           out_side_q;

  always_ff @(posedge clk_i) begin
    if (en[NStages]) begin
      lpwm_q     <= lpwm;
      rpwm_q     <= rpwm;
      out_side_q <= side_q[NStages-1];
    end
  end

  assign out_valid_o    = v_q[NStages];
  assign left_pwm_o     = lpwm_q;
  assign right_pwm_o    = rpwm_q;
  assign left_bridge_o  = out_side_q.lbr;
  assign right_bridge_o = out_side_q.rbr;
  assign emergency_o    = out_side_q.emergency;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef SYNTH
  // an emergency stop always comes with zero duty and coasting bridges
  a_emerg_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && emergency_o |-> left_pwm_o == '0 && right_pwm_o == '0
      && left_bridge_o == BrCoast && right_bridge_o == BrCoast)
    else $error("emergency result with drive applied");

  // a coasting wheel is never driven
  a_coast_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (left_bridge_o == BrCoast || right_bridge_o == BrCoast)
      |-> left_pwm_o == '0 && right_pwm_o == '0)
    else $error("coasting wheel with nonzero duty");

  // brake is never issued
  a_no_brake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> left_bridge_o != BrBrake && right_bridge_o != BrBrake)
    else $error("brake code issued");

  // input is held off only when every stage is full and the output stalls
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&v_q) && !out_ready_i)
    else $error("input stalled with room in the pipeline");
`endif

endmodule
